// File: hw/rtl/mfw_pkg.sv
package mfw_pkg;

	localparam int PIX_W         = 8;
	localparam int CFG_W         = 12;
	localparam int DEF_MAX_HALF  = 1;
	localparam int DEF_MAX_WIDTH = 2048;
	localparam int SLOT_MAX_W    = 4;
	localparam int APB_AW        = 4;
	localparam int APB_DW        = 32;

	localparam logic [CFG_W-1:0] RST_WIDTH  = 12'd640;
	localparam logic [CFG_W-1:0] RST_HEIGHT = 12'd480;
	localparam logic             RST_HALF   = 1'b1;

	localparam logic OP_PIXEL = 1'b0;

	typedef enum logic [1:0] {
		REG_WIDTH,
		REG_HEIGHT,
		REG_HALF_W,
		REG_HALF_H
	} reg_idx_t;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		logic                  en;
		logic [SLOT_MAX_W-1:0] slot;
		pix_t                  data;
	} wr_t;

	typedef struct packed {
		logic                  valid;
		logic                  first;
		logic                  last;
		logic [SLOT_MAX_W-1:0] slot_up;
		logic [SLOT_MAX_W-1:0] slot_mid;
		logic [SLOT_MAX_W-1:0] slot_dn;
	} req_t;

	typedef struct packed {
		logic       valid;
		logic       first;
		logic       last;
		pix_t [2:0] mid;
		pix_t [2:0] rt;
	} col_t;

	function automatic pix_t min2(input pix_t a, input pix_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic pix_t max2(input pix_t a, input pix_t b);
		return (a < b) ? b : a;
	endfunction

	function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	// column k of the window is w[3k+2:3k]
	function automatic pix_t median9(input pix_t [8:0] w);
		pix_t [2:0] lo;
		pix_t [2:0] md;
		pix_t [2:0] hi;
		for (int k = 0; k < 3; k++) begin
			lo[k] = min2(min2(w[3*k], w[3*k+1]), w[3*k+2]);
			md[k] = med3(w[3*k], w[3*k+1], w[3*k+2]);
			hi[k] = max2(max2(w[3*k], w[3*k+1]), w[3*k+2]);
		end
		return med3(max2(max2(lo[0], lo[1]), lo[2]), med3(md[0], md[1], md[2]),
			min2(min2(hi[0], hi[1]), hi[2]));
	endfunction

endpackage

// File: hw/rtl/mfw_if.sv
interface mfw_pix_if import mfw_pkg::*; ();
	logic valid;
	logic ready;
	logic opcode;
	pix_t pixel;

	modport source(output valid, output opcode, output pixel, input ready);
	modport sink(input valid, input opcode, input pixel, output ready);
endinterface

interface mfw_med_if import mfw_pkg::*; ();
	logic valid;
	logic ready;
	pix_t median;
	logic last;

	modport source(output valid, output median, output last, input ready);
	modport sink(input valid, input median, input last, output ready);
endinterface

// File: hw/rtl/mfw_ctrl.sv
module mfw_ctrl import mfw_pkg::*; #(
	parameter int MAX_HALF = DEF_MAX_HALF,
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	localparam int COL_W = $clog2(MAX_WIDTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	input  logic              fire,
	input  logic              load1,
	input  logic              opcode,
	input  pix_t              pixel,
	output wr_t               wr,
	output logic [COL_W-1:0]  wr_col,
	output req_t              req_s1,
	output logic [COL_W-1:0]  col_mid_s1,
	output logic [COL_W-1:0]  col_rt_s1
);

	localparam int ROW_SLOTS = 4 * MAX_HALF + 2;
	localparam int SLOT_W = $clog2(ROW_SLOTS);
	localparam int LAG_W = COL_W + 2;

	logic [CFG_W-1:0] width_q, height_q;
	logic             half_w_q, half_h_q;
	logic             cfg_wr;
	reg_idx_t         cfg_idx;

	logic [COL_W-1:0] w_m1;
	logic [CFG_W-1:0] h_m1;
	logic [LAG_W-1:0] lag;

	logic [COL_W-1:0]  in_col_q, out_col_q;
	logic [CFG_W-1:0]  in_row_q, out_row_q;
	logic [SLOT_W-1:0] in_slot_q, out_slot_q;
	logic [LAG_W-1:0]  gap_q;

	logic              in_open, is_pix, emit, fin;
	logic [SLOT_W-1:0] in_slot_nx, out_slot_nx, out_slot_pv;

	logic              req_valid_s1, req_first_s1, req_last_s1;
	logic [SLOT_W-1:0] slot_up_s1, slot_mid_s1, slot_dn_s1;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[APB_AW-1:2]);

	always_comb begin
		unique case (cfg_idx)
			REG_WIDTH:  prdata = APB_DW'(width_q);
			REG_HEIGHT: prdata = APB_DW'(height_q);
			REG_HALF_W: prdata = APB_DW'(half_w_q);
			REG_HALF_H: prdata = APB_DW'(half_h_q);
			default:    prdata = '0;
		endcase
	end

	always_comb begin
		if (width_q == '0) begin
			w_m1 = '0;
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w_m1 = COL_W'(MAX_WIDTH - 1);
		end else begin
			w_m1 = COL_W'(width_q - 1'b1);
		end
		h_m1 = (height_q == '0) ? '0 : height_q - 1'b1;
		lag  = (half_h_q ? LAG_W'(w_m1) + LAG_W'(1) : '0) + LAG_W'(half_w_q);
	end

	always_comb begin
		in_slot_nx  = (in_slot_q == SLOT_W'(ROW_SLOTS - 1)) ? '0 : in_slot_q + 1'b1;
		out_slot_nx = (out_slot_q == SLOT_W'(ROW_SLOTS - 1)) ? '0 : out_slot_q + 1'b1;
		out_slot_pv = (out_slot_q == '0) ? SLOT_W'(ROW_SLOTS - 1) : out_slot_q - 1'b1;
		in_open     = in_row_q <= h_m1;
		is_pix      = (opcode == OP_PIXEL) && in_open;
		emit        = is_pix ? (gap_q >= lag) : (!in_open && gap_q != '0);
		fin         = (out_row_q == h_m1) && (out_col_q == w_m1);
	end

	assign wr.en   = fire && is_pix;
	assign wr.slot = SLOT_MAX_W'(in_slot_q);
	assign wr.data = pixel;
	assign wr_col  = in_col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= RST_WIDTH;
			height_q   <= RST_HEIGHT;
			half_w_q   <= RST_HALF;
			half_h_q   <= RST_HALF;
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
			gap_q      <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
				REG_HEIGHT: height_q <= pwdata[CFG_W-1:0];
				REG_HALF_W: half_w_q <= pwdata[0];
				REG_HALF_H: half_h_q <= pwdata[0];
				default:    ;
			endcase
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
			gap_q      <= '0;
		end else if (fire) begin
			// frame complete: restart every counter
			if (emit && fin) begin
				in_col_q   <= '0;
				in_row_q   <= '0;
				in_slot_q  <= '0;
				out_col_q  <= '0;
				out_row_q  <= '0;
				out_slot_q <= '0;
				gap_q      <= '0;
			end else begin
				if (is_pix) begin
					if (in_col_q == w_m1) begin
						in_col_q  <= '0;
						in_row_q  <= in_row_q + 1'b1;
						in_slot_q <= in_slot_nx;
					end else begin
						in_col_q <= in_col_q + 1'b1;
					end
				end
				if (emit) begin
					if (out_col_q == w_m1) begin
						out_col_q  <= '0;
						out_row_q  <= out_row_q + 1'b1;
						out_slot_q <= out_slot_nx;
					end else begin
						out_col_q <= out_col_q + 1'b1;
					end
				end
				if (is_pix && !emit) begin
					gap_q <= gap_q + 1'b1;
				end else if (!is_pix && emit) begin
					gap_q <= gap_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (load1) begin
			req_valid_s1 <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			req_first_s1 <= !half_w_q || (out_col_q == '0);
			req_last_s1  <= fin;
			slot_mid_s1  <= out_slot_q;
			slot_up_s1   <= (half_h_q && out_row_q != '0) ? out_slot_pv : out_slot_q;
			slot_dn_s1   <= (half_h_q && out_row_q != h_m1) ? out_slot_nx : out_slot_q;
			col_mid_s1   <= out_col_q;
			col_rt_s1    <= (half_w_q && out_col_q != w_m1) ? out_col_q + 1'b1 : out_col_q;
		end
	end

	assign req_s1.valid    = req_valid_s1;
	assign req_s1.first    = req_first_s1;
	assign req_s1.last     = req_last_s1;
	assign req_s1.slot_up  = SLOT_MAX_W'(slot_up_s1);
	assign req_s1.slot_mid = SLOT_MAX_W'(slot_mid_s1);
	assign req_s1.slot_dn  = SLOT_MAX_W'(slot_dn_s1);

	a_gap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		gap_q <= lag)
		else $error("pending count beyond window lag");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !in_open && gap_q == '0 |=> !req_valid_s1)
		else $error("result raised with nothing pending");

endmodule

// File: hw/rtl/mfw_line_store.sv
module mfw_line_store import mfw_pkg::*; #(
	parameter int MAX_HALF = DEF_MAX_HALF,
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	localparam int COL_W = $clog2(MAX_WIDTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  wr_t              wr,
	input  logic [COL_W-1:0] wr_col,
	input  req_t             req_s1,
	input  logic [COL_W-1:0] col_mid_s1,
	input  logic [COL_W-1:0] col_rt_s1,
	input  logic             load2,
	output col_t             col_s2
);

	localparam int ROW_SLOTS = 4 * MAX_HALF + 2;
	localparam int SLOT_W = $clog2(ROW_SLOTS);

	pix_t              rd_mid_s2 [ROW_SLOTS];
	pix_t              rd_rt_s2  [ROW_SLOTS];
	logic              valid_s2, first_s2, last_s2;
	logic [SLOT_W-1:0] slot_up_s2, slot_mid_s2, slot_dn_s2;

	for (genvar b = 0; b < ROW_SLOTS; b++) begin : g_bank
		pix_t mem [MAX_WIDTH];

		always_ff @(posedge clk) begin
			if (wr.en && wr.slot[SLOT_W-1:0] == SLOT_W'(b)) begin
				mem[wr_col] <= wr.data;
			end
			if (load2) begin
				rd_mid_s2[b] <= mem[col_mid_s1];
				rd_rt_s2[b]  <= mem[col_rt_s1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load2) begin
			valid_s2 <= req_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load2) begin
			first_s2    <= req_s1.first;
			last_s2     <= req_s1.last;
			slot_up_s2  <= req_s1.slot_up[SLOT_W-1:0];
			slot_mid_s2 <= req_s1.slot_mid[SLOT_W-1:0];
			slot_dn_s2  <= req_s1.slot_dn[SLOT_W-1:0];
		end
	end

	always_comb begin
		col_s2.valid  = valid_s2;
		col_s2.first  = first_s2;
		col_s2.last   = last_s2;
		col_s2.mid[0] = rd_mid_s2[slot_up_s2];
		col_s2.mid[1] = rd_mid_s2[slot_mid_s2];
		col_s2.mid[2] = rd_mid_s2[slot_dn_s2];
		col_s2.rt[0]  = rd_rt_s2[slot_up_s2];
		col_s2.rt[1]  = rd_rt_s2[slot_mid_s2];
		col_s2.rt[2]  = rd_rt_s2[slot_dn_s2];
	end

	a_read_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_s1.valid && load2 |=> valid_s2)
		else $error("issued read lost between stages");

endmodule

// File: hw/rtl/mfw_median.sv
module mfw_median import mfw_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  col_t         col_s2,
	output logic         load3,
	mfw_med_if.source    results
);

	pix_t [8:0] win_s3;
	pix_t [2:0] prev_q;
	logic       valid_s3, last_s3;
	logic       load_out;

	assign load_out = !results.valid || results.ready;
	assign load3    = !valid_s3 || load_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3      <= 1'b0;
			results.valid <= 1'b0;
		end else begin
			if (load3) begin
				valid_s3 <= col_s2.valid;
			end
			if (load_out) begin
				results.valid <= valid_s3;
			end
		end
	end

	// left column = centre at row start or zero half width, else prior centre
	always_ff @(posedge clk) begin
		if (load3 && col_s2.valid) begin
			win_s3  <= {col_s2.rt, col_s2.mid, (col_s2.first ? col_s2.mid : prev_q)};
			last_s3 <= col_s2.last;
			prev_q  <= col_s2.mid;
		end
		if (load_out && valid_s3) begin
			results.median <= median9(win_s3);
			results.last   <= last_s3;
		end
	end

	a_window_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !load3 |=> valid_s3 && $stable(win_s3))
		else $error("window changed while stalled");

endmodule

// File: hw/rtl/median_filter_window_top.sv
// 3x3 (or 3x1, 1x3, 1x1) median filter on an 8-bit raster pixel stream, edge pixels
// replicated at the image borders. One transaction is taken per clock unless the output
// stalls; each pixel transaction past the window lag (half-height rows plus half-width
// pixels) yields one median, and after the last pixel one drain transaction per
// outstanding median flushes the rest, the final median of the frame carrying last. A
// median passes the counter stage, line-store read, window register and median network.
// The line store holds 4*MAX_HALF+2 rows of MAX_WIDTH pixels in one bank per row, each
// bank written once and read at two columns per cycle while its read stage advances.
// Register writes restart the frame and are only to be made while the filter is empty.
module median_filter_window_top import mfw_pkg::*; #(
	parameter int MAX_HALF = DEF_MAX_HALF,
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	mfw_pix_if.sink           pixels,
	mfw_med_if.source         results,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int COL_W = $clog2(MAX_WIDTH);

	wr_t              wr;
	logic [COL_W-1:0] wr_col, col_mid_s1, col_rt_s1;
	req_t             req_s1;
	col_t             col_s2;
	logic             fire, load1, load2, load3;

	assign load2        = !col_s2.valid || load3;
	assign load1        = !req_s1.valid || load2;
	assign pixels.ready = load1;
	assign fire         = pixels.valid && load1;

	mfw_ctrl #(
		.MAX_HALF  (MAX_HALF),
		.MAX_WIDTH (MAX_WIDTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.fire       (fire),
		.load1      (load1),
		.opcode     (pixels.opcode),
		.pixel      (pixels.pixel),
		.wr         (wr),
		.wr_col     (wr_col),
		.req_s1     (req_s1),
		.col_mid_s1 (col_mid_s1),
		.col_rt_s1  (col_rt_s1)
	);

	mfw_line_store #(
		.MAX_HALF  (MAX_HALF),
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr),
		.wr_col     (wr_col),
		.req_s1     (req_s1),
		.col_mid_s1 (col_mid_s1),
		.col_rt_s1  (col_rt_s1),
		.load2      (load2),
		.col_s2     (col_s2)
	);

	mfw_median u_median (
		.clk     (clk),
		.arst_n  (arst_n),
		.col_s2  (col_s2),
		.load3   (load3),
		.results (results)
	);

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import mfw_pkg::*;

	localparam logic OP_DRAIN  = 1'b1;
	localparam int   ROW_BANKS = 4 * DEF_MAX_HALF + 2;
	localparam int   SETTLE    = 8;
	localparam int   LIMIT_NS  = 12 * 2_000_000;

	typedef enum logic [1:0] {TX_ITEM, TX_WRITE, TX_PACE} tx_kind_t;

	typedef struct {
		tx_kind_t    kind;
		logic        opcode;
		pix_t        pixel;
		reg_idx_t    idx;
		logic [31:0] value;
		int          gap_pct;
		int          stall_pct;
	} tx_t;

	typedef struct {
		pix_t median;
		logic last;
	} median_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	mfw_pix_if pix_bus();
	mfw_med_if med_bus();

	median_filter_window_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.pixels(pix_bus),
		.results(med_bus),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	pix_t        row_bank [ROW_BANKS][DEF_MAX_WIDTH];
	logic [11:0] cfg_width  = RST_WIDTH;
	logic [11:0] cfg_height = RST_HEIGHT;
	logic        cfg_half_w = RST_HALF;
	logic        cfg_half_h = RST_HALF;
	int          col_in     = 0;
	int          row_in     = 0;
	int          col_out    = 0;
	int          row_out    = 0;

	tx_t     pending_tx[$];
	median_t medians_due[$];

	int gap_pct    = 0;
	int stall_pct  = 0;
	int apb_step   = 0;
	int quiet      = 0;
	int stim_items = 0;
	int n_items    = 0;
	int n_writes   = 0;
	int n_medians  = 0;
	int n_frames   = 0;
	int n_errors   = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int eff_width(input logic [11:0] raw);
		if (raw == 0) return 1;
		if (raw > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
		return int'(raw);
	endfunction

	function automatic int eff_height(input logic [11:0] raw);
		return (raw == 0) ? 1 : int'(raw);
	endfunction

	task automatic restart_frame();
		col_in  = 0;
		row_in  = 0;
		col_out = 0;
		row_out = 0;
	endtask

	task automatic load_register(input reg_idx_t idx, input logic [31:0] value);
		unique case (idx)
			REG_WIDTH:  cfg_width  = value[CFG_W-1:0];
			REG_HEIGHT: cfg_height = value[CFG_W-1:0];
			REG_HALF_W: cfg_half_w = value[0];
			REG_HALF_H: cfg_half_h = value[0];
		endcase
		restart_frame();
	endtask

	task automatic filter_pixel(input logic op, input pix_t px);
		int      w, h, hw, hh, lag, total, n_in, n_out, n, rr, cc, j;
		bit      release_one;
		pix_t    win [9];
		pix_t    v;
		median_t res;
		w     = eff_width(cfg_width);
		h     = eff_height(cfg_height);
		hw    = int'(cfg_half_w);
		hh    = int'(cfg_half_h);
		lag   = hh * w + hw;
		total = w * h;
		n_in  = row_in * w + col_in;
		n_out = row_out * w + col_out;
		if (op == OP_PIXEL && n_in < total) begin
			row_bank[row_in % ROW_BANKS][col_in] = px;
			col_in++;
			if (col_in >= w) begin
				col_in = 0;
				row_in++;
			end
			release_one = (n_in + 1 - n_out > lag);
		end else begin
			release_one = (n_in == total && n_out < total);
		end
		if (release_one) begin
			n = 0;
			for (int dy = -hh; dy <= hh; dy++) begin
				rr = row_out + dy;
				if (rr < 0) rr = 0;
				if (rr > h - 1) rr = h - 1;
				for (int dx = -hw; dx <= hw; dx++) begin
					cc = col_out + dx;
					if (cc < 0) cc = 0;
					if (cc > w - 1) cc = w - 1;
					v = row_bank[rr % ROW_BANKS][cc];
					j = n;
					while (j > 0 && win[j-1] > v) begin
						win[j] = win[j-1];
						j--;
					end
					win[j] = v;
					n++;
				end
			end
			res.median = win[n/2];
			res.last   = (row_out == h - 1) && (col_out == w - 1);
			medians_due = {medians_due, res};
			if (res.last) begin
				restart_frame();
			end else begin
				col_out++;
				if (col_out >= w) begin
					col_out = 0;
					row_out++;
				end
			end
		end
	endtask

	task automatic report_mismatch(input string msg);
		n_errors++;
		if (n_errors <= 100) $display("MISMATCH at %0t ns: %s", $time, msg);
	endtask

	// stimulus queue helpers
	task automatic push_item(input logic op, input pix_t px);
		tx_t t;
		t.kind   = TX_ITEM;
		t.opcode = op;
		t.pixel  = px;
		pending_tx = {pending_tx, t};
	endtask

	task automatic push_write(input reg_idx_t idx, input int raw);
		tx_t t;
		t.kind  = TX_WRITE;
		t.idx   = idx;
		t.value = $urandom;
		if (idx == REG_WIDTH || idx == REG_HEIGHT) t.value[CFG_W-1:0] = raw[CFG_W-1:0];
		else t.value[0] = raw[0];
		pending_tx = {pending_tx, t};
	endtask

	task automatic push_setup(input int w_raw, input int h_raw, input int hw, input int hh);
		push_write(REG_WIDTH, w_raw);
		push_write(REG_HEIGHT, h_raw);
		push_write(REG_HALF_W, hw);
		push_write(REG_HALF_H, hh);
	endtask

	task automatic push_pace(input int gap, input int stall);
		tx_t t;
		t.kind      = TX_PACE;
		t.gap_pct   = gap;
		t.stall_pct = stall;
		pending_tx = {pending_tx, t};
	endtask

	// 0 <= cut < total abandons after that many pixels
	task automatic push_frame(input int w, input int h, input int hw, input int hh, input int cut);
		int   total, lag, stop, style, lo;
		pix_t px;
		total = w * h;
		lag   = hh * w + hw;
		stop  = (cut >= 0 && cut < total) ? cut : total;
		style = $urandom_range(3);
		lo    = $urandom_range(250);
		for (int k = 0; k < stop; k++) begin
			if ($urandom_range(19) == 0) push_item(OP_DRAIN, PIX_W'($urandom));
			case (style)
				1:       px = PIX_W'($urandom_range(lo + 5, lo));
				2:       px = {8{1'($urandom_range(1))}};
				default: px = PIX_W'($urandom);
			endcase
			push_item(OP_PIXEL, px);
			stim_items++;
		end
		if (stop < total) begin
			repeat ($urandom_range(2)) push_item(OP_DRAIN, PIX_W'($urandom));
		end else begin
			repeat ((lag < total) ? lag : total) begin
				if ($urandom_range(4) == 0) push_item(OP_PIXEL, PIX_W'($urandom));
				else push_item(OP_DRAIN, PIX_W'($urandom));
				stim_items++;
			end
			if ($urandom_range(9) == 0) push_item(OP_DRAIN, PIX_W'($urandom));
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		pix_bus.valid  = 1'b0;
		pix_bus.opcode = OP_PIXEL;
		pix_bus.pixel  = '0;
		med_bus.ready  = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		tx_t  head;
		logic send;
		if (!arst_n) begin
			pix_bus.valid <= 1'b0;
			psel          <= 1'b0;
			penable       <= 1'b0;
			pwrite        <= 1'b0;
			apb_step = 0;
			quiet    = 0;
		end else begin
			if (pix_bus.valid && pix_bus.ready) begin
				filter_pixel(pix_bus.opcode, pix_bus.pixel);
				n_items++;
				quiet = 0;
			end else if (medians_due.size() == 0) begin
				quiet++;
			end else begin
				quiet = 0;
			end
			if (apb_step == 1) begin
				penable <= 1'b1;
				apb_step = 2;
			end else if (apb_step == 2) begin
				if (pready) begin
					load_register(reg_idx_t'(paddr[3:2]), pwdata);
					n_writes++;
					psel    <= 1'b0;
					penable <= 1'b0;
					pwrite  <= 1'b0;
					apb_step = 0;
				end
			end else if (!pix_bus.valid || pix_bus.ready) begin
				while (pending_tx.size() != 0 && pending_tx[0].kind == TX_PACE) begin
					gap_pct   = pending_tx[0].gap_pct;
					stall_pct = pending_tx[0].stall_pct;
					void'(pending_tx.pop_front());
				end
				send = 1'b0;
				if (pending_tx.size() != 0) begin
					head = pending_tx[0];
					if (head.kind == TX_ITEM && $urandom_range(99) >= gap_pct) begin
						void'(pending_tx.pop_front());
						pix_bus.opcode <= head.opcode;
						pix_bus.pixel  <= head.pixel;
						send = 1'b1;
					end else if (head.kind == TX_WRITE && quiet >= SETTLE) begin
						void'(pending_tx.pop_front());
						psel    <= 1'b1;
						penable <= 1'b0;
						pwrite  <= 1'b1;
						paddr   <= {head.idx, 2'b00};
						pwdata  <= head.value;
						apb_step = 1;
					end
				end
				pix_bus.valid <= send;
			end
		end
	end

	always @(posedge clk) begin
		median_t due;
		if (!arst_n) begin
			med_bus.ready <= 1'b0;
		end else begin
			if (med_bus.valid && med_bus.ready) begin
				if (medians_due.size() == 0) begin
					report_mismatch($sformatf("median %0d (last %0b) with none due",
						med_bus.median, med_bus.last));
				end else begin
					due = medians_due.pop_front();
					if (med_bus.median !== due.median)
						report_mismatch($sformatf("result %0d: median %0d, expected %0d",
							n_medians, med_bus.median, due.median));
					if (med_bus.last !== due.last)
						report_mismatch($sformatf("result %0d: last %0b, expected %0b",
							n_medians, med_bus.last, due.last));
					n_medians++;
					if (due.last) n_frames++;
				end
			end
			med_bus.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		int w, h, w_raw, h_raw, hw, hh, r, total, cut;
		push_pace(7, 80);

		push_setup(3, 2, 1, 1);
		push_item(OP_DRAIN, 8'h5A);
		push_item(OP_PIXEL, 8'h00);
		push_item(OP_PIXEL, 8'hFF);
		push_item(OP_PIXEL, 8'h55);
		push_item(OP_PIXEL, 8'hAA);
		push_item(OP_PIXEL, 8'h0F);
		push_item(OP_PIXEL, 8'hF0);
		push_item(OP_DRAIN, 8'h00);
		push_item(OP_DRAIN, 8'hFF);
		push_item(OP_DRAIN, 8'h00);
		push_item(OP_PIXEL, 8'h77);
		push_item(OP_DRAIN, 8'hFF);
		// abandon a partial frame with the next writes
		push_item(OP_PIXEL, 8'h01);
		push_item(OP_PIXEL, 8'h02);

		push_setup(0, 0, 1, 1);
		push_item(OP_PIXEL, 8'h80);
		push_item(OP_DRAIN, 8'h00);

		push_setup(2, 2, 0, 0);
		push_item(OP_PIXEL, 8'hFE);
		push_item(OP_PIXEL, 8'h01);
		push_item(OP_PIXEL, 8'h7F);
		push_item(OP_PIXEL, 8'h80);

		push_setup(4, 1, 1, 0);
		push_item(OP_PIXEL, 8'h10);
		push_item(OP_PIXEL, 8'hEF);
		push_item(OP_PIXEL, 8'h20);
		push_item(OP_PIXEL, 8'hDF);
		push_item(OP_DRAIN, 8'h00);

		stim_items = 0;
		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) push_pace(80, 7);
			if (ph == 2) push_pace(0, 0);
			while (stim_items < 250 * (ph + 1)) begin
				r = $urandom_range(99);
				if (r < 70) w = $urandom_range(8, 1);
				else if (r < 95) w = $urandom_range(40, 9);
				else w = $urandom_range(200, 41);
				h  = (w > 40) ? $urandom_range(3, 1) : $urandom_range(10, 1);
				hw = $urandom_range(1);
				hh = $urandom_range(1);
				w_raw = (w == 1 && $urandom_range(1)) ? 0 : w;
				h_raw = (h == 1 && $urandom_range(1)) ? 0 : h;
				push_setup(w_raw, h_raw, hw, hh);
				total = w * h;
				repeat ($urandom_range(3, 1)) begin
					cut = ($urandom_range(9) == 0) ? $urandom_range(total - 1) : -1;
					push_frame(w, h, hw, hh, cut);
					if (cut >= 0) break;
				end
			end
		end

		push_setup(12'hFFF, 1, 1, 0);
		push_frame(DEF_MAX_WIDTH, 1, 1, 0, 100);
		push_setup(DEF_MAX_WIDTH, 4095, 0, 1);
		push_frame(DEF_MAX_WIDTH, 4095, 0, 1, 40);
		push_setup(1, 4095, 1, 1);
		push_frame(1, 4095, 1, 1, 60);
		push_setup(5, 3, 1, 1);
		push_frame(5, 3, 1, 1, -1);

		@(posedge clk);
		while (pending_tx.size() != 0 || pix_bus.valid || apb_step != 0 ||
				medians_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Run covered %0d pixel and drain transactions and %0d register writes,",
			n_items, n_writes);
		$display("comparing %0d medians over %0d completed frames; %0d mismatches.",
			n_medians, n_frames, n_errors);
		if (n_errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#LIMIT_NS;
		$display("Timed out with %0d medians still due", medians_due.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
